[design/csr_sms_pkg.sv]
// csr_sms_pkg: item kind and status codes shared by the sparse matrix store
// no dependencies
`default_nettype none

package csr_sms_pkg;

	// width of the row and column index fields
	localparam int unsigned IDX_W = 9;
	// width of a stored value and of the result field
	localparam int unsigned VAL_W = 32;
	localparam int unsigned RES_W = 40;

	// item kinds
	typedef enum logic [1:0] {
		K_INSERT = 2'd0,
		K_READ   = 2'd1,
		K_TRACE  = 2'd2,
		K_CLEAR  = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_RANGE      = 3'd1,
		ST_NOT_SQUARE = 3'd2,
		ST_FULL       = 3'd3,
		ST_ORDER      = 3'd4
	} status_t;

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
	localparam logic [1:0] CFG_NUM_COLS = 2'd1;

endpackage

`default_nettype wire

[design/csr_sparse_matrix_store_top.sv]
// compressed-sparse-row matrix store with a one-entry-at-a-time lookup sequencer
// depends on csr_sms_pkg
`default_nettype none

//  channel  signals                                  direction  beat
//  in       in_valid in_ready kind row_index         in         one item
//           col_index value
//  out      out_valid out_ready result_value status  out        one result per item
//  cfg      cfg_valid cfg_ready cfg_index cfg_data   in         one register write
//
//  steps per item, set by one pointer-memory port and one entry-memory port:
//  stored insert sweeps rows up to its row, then commits; other inserts, clear,
//  refused items go to finish; read looks up row start and end, then reads and
//  compares each entry; trace does so per diagonal row; column match ends a scan;
//  reset clears counters only; rows above the last insert row take the entry count
//  as pointer, so no clearing pass; a held result stalls the next finish step

module csr_sparse_matrix_store_top
	import csr_sms_pkg::*;
#(
	parameter int unsigned MAX_ROWS = 256,
	parameter int unsigned MAX_COLS = 256,
	parameter int unsigned CAPACITY = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// item channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              kind,
	input  wire logic [IDX_W-1:0]        row_index,
	input  wire logic [IDX_W-1:0]        col_index,
	input  wire logic signed [VAL_W-1:0] value,
	// result channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [RES_W-1:0]      result_value,
	output logic [2:0]                   status,
	// configuration channel
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [IDX_W-1:0]        cfg_data
);

	localparam int unsigned IDX_MAX = (1 << IDX_W) - 1;
	localparam int unsigned RMAX = (MAX_ROWS > IDX_MAX) ? IDX_MAX : MAX_ROWS;
	localparam int unsigned CMAX = (MAX_COLS > IDX_MAX) ? IDX_MAX : MAX_COLS;
	localparam int unsigned RW   = $clog2(MAX_ROWS + 1);
	localparam int unsigned RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned EAW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SWEEP    = 9'b000000010,
		S_COMMIT   = 9'b000000100,
		S_LK_LO    = 9'b000001000,
		S_LK_HI    = 9'b000010000,
		S_LK_END   = 9'b000100000,
		S_SCAN_RD  = 9'b001000000,
		S_SCAN_CMP = 9'b010000000,
		S_FIN      = 9'b100000000
	} state_t;

	state_t                   state_q;
	logic [IDX_W-1:0]         num_rows_q;
	logic [IDX_W-1:0]         num_cols_q;
	logic [CW-1:0]            count_q;
	logic [RW-1:0]            last_q;
	logic                     out_valid_q;
	logic signed [RES_W-1:0]  out_res_q;
	status_t                  out_st_q;

	// item and work registers
	kind_t                    kind_q;
	logic [RW-1:0]            row_q;
	logic [IDX_W-1:0]         col_q;
	logic [VAL_W-1:0]         val_q;
	logic [RW-1:0]            sw_q;
	logic [RW-1:0]            d_q;
	logic [CW-1:0]            k_q;
	logic [CW-1:0]            end_q;
	logic                     flag_q;
	logic signed [RES_W-1:0]  acc_q;
	logic signed [RES_W-1:0]  res_q;
	status_t                  st_q;

	// memories
	logic [CW-1:0]            rs_mem [MAX_ROWS];
	logic [VAL_W-1:0]         ent_val_mem [CAPACITY];
	logic [IDX_W-1:0]         ent_col_mem [CAPACITY];
	logic [CW-1:0]            rs_rd_q;
	logic [VAL_W-1:0]         val_rd_q;
	logic [IDX_W-1:0]         col_rd_q;

	logic [IDX_W-1:0]         n_use;
	logic [IDX_W-1:0]         m_use;
	logic                     in_range;
	logic [RW-1:0]            row_in;
	logic                     in_fire;
	logic                     out_free;
	logic [RW-1:0]            tgt_row;
	logic [IDX_W-1:0]         tgt_col;
	logic [RAW-1:0]           rs_addr;
	logic                     rs_we;
	logic                     ent_we;
	logic                     look_done;
	logic signed [RES_W-1:0]  look_val;
	logic signed [RES_W-1:0]  acc_sum;
	logic                     row_hit;

	// rows and columns in use, limited to the maxima
	assign n_use = (num_rows_q > IDX_W'(RMAX)) ? IDX_W'(RMAX) : num_rows_q;
	assign m_use = (num_cols_q > IDX_W'(CMAX)) ? IDX_W'(CMAX) : num_cols_q;
	assign in_range = (row_index != '0) && (row_index <= n_use) &&
		(col_index != '0) && (col_index <= m_use);
	assign row_in = RW'(row_index);

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// lookup target: the diagonal element for trace, the item's element for read
	assign tgt_row = (kind_q == K_TRACE) ? d_q : row_q;
	assign tgt_col = (kind_q == K_TRACE) ? IDX_W'(d_q) : col_q;

	// row pointer memory address: start of the row, then its end, or the sweep row
	always_comb begin
		rs_addr = RAW'(tgt_row);
		if (state_q == S_LK_LO) begin
			rs_addr = RAW'(tgt_row - RW'(1));
		end
		if (state_q == S_SWEEP) begin
			rs_addr = RAW'(sw_q);
		end
	end

	assign rs_we  = (state_q == S_SWEEP);
	assign ent_we = (state_q == S_COMMIT);

	// scan step: end of row or a column match finishes the lookup
	assign row_hit = (col_rd_q == tgt_col);
	always_comb begin
		look_done = 1'b0;
		look_val  = '0;
		if (state_q == S_SCAN_RD && !(k_q < end_q)) begin
			look_done = 1'b1;
		end
		if (state_q == S_SCAN_CMP && row_hit) begin
			look_done = 1'b1;
			look_val  = RES_W'(signed'(val_rd_q));
		end
	end

	// accumulator adder for the trace sum
	assign acc_sum = acc_q + look_val;

	// row pointer memory: sweep writes, one registered read
	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[RAW'(sw_q)] <= count_q;
		end
		rs_rd_q <= rs_mem[rs_addr];
	end

	// entry memories: append on commit, one registered read during the scan
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_val_mem[count_q[EAW-1:0]] <= val_q;
			ent_col_mem[count_q[EAW-1:0]] <= col_q;
		end
		val_rd_q <= ent_val_mem[k_q[EAW-1:0]];
		col_rd_q <= ent_col_mem[k_q[EAW-1:0]];
	end

	// control: sequencer, store counters, configuration and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_rows_q  <= IDX_W'(256);
			num_cols_q  <= IDX_W'(256);
			count_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NUM_ROWS: num_rows_q <= cfg_data;
					CFG_NUM_COLS: num_cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_FIN;
						case (kind_t'(kind))
							K_INSERT: begin
								if (in_range && value != '0 && !(row_in < last_q) &&
									(count_q < CW'(CAPACITY))) begin
									state_q <= (last_q < row_in) ? S_SWEEP : S_COMMIT;
								end
							end
							K_READ: begin
								if (in_range) begin
									state_q <= S_LK_LO;
								end
							end
							K_TRACE: begin
								if (n_use == m_use && n_use != '0) begin
									state_q <= S_LK_LO;
								end
							end
							K_CLEAR: begin
								count_q <= '0;
								last_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SWEEP: begin
					if (sw_q == row_q - RW'(1)) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					count_q <= count_q + CW'(1);
					last_q  <= row_q;
					state_q <= S_FIN;
				end
				S_LK_LO:  state_q <= S_LK_HI;
				S_LK_HI:  state_q <= S_LK_END;
				S_LK_END: state_q <= S_SCAN_RD;
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
					if (look_done) begin
						if (kind_q == K_TRACE && d_q != RW'(n_use)) begin
							state_q <= S_LK_LO;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN_CMP: begin
					state_q <= S_SCAN_RD;
					if (look_done) begin
						if (kind_q == K_TRACE && d_q != RW'(n_use)) begin
							state_q <= S_LK_LO;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					kind_q <= kind_t'(kind);
					row_q  <= row_in;
					col_q  <= col_index;
					val_q  <= value;
					sw_q   <= last_q;
					d_q    <= RW'(1);
					acc_q  <= '0;
					res_q  <= '0;
					st_q   <= ST_OK;
					case (kind_t'(kind))
						K_INSERT: begin
							if (!in_range) begin
								st_q <= ST_RANGE;
							end else if (value == '0) begin
								st_q <= ST_OK;
							end else if (row_in < last_q) begin
								st_q <= ST_ORDER;
							end else if (!(count_q < CW'(CAPACITY))) begin
								st_q <= ST_FULL;
							end
						end
						K_READ: begin
							if (!in_range) begin
								st_q <= ST_RANGE;
							end
						end
						K_TRACE: begin
							if (n_use != m_use) begin
								st_q <= ST_NOT_SQUARE;
							end
						end
						default: ;
					endcase
				end
			end
			S_SWEEP: sw_q <= sw_q + RW'(1);
			// row start: from memory below the last stored row, else the entry count
			S_LK_LO: flag_q <= (tgt_row - RW'(1)) < last_q;
			S_LK_HI: begin
				k_q    <= flag_q ? rs_rd_q : count_q;
				flag_q <= tgt_row < last_q;
			end
			S_LK_END: end_q <= flag_q ? rs_rd_q : count_q;
			S_SCAN_RD, S_SCAN_CMP: begin
				if (state_q == S_SCAN_CMP && !look_done) begin
					k_q <= k_q + CW'(1);
				end
				if (look_done) begin
					if (kind_q == K_TRACE) begin
						acc_q <= acc_sum;
						res_q <= acc_sum;
						d_q   <= d_q + RW'(1);
					end else begin
						res_q <= look_val;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_res_q <= res_q;
					out_st_q  <= st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign status       = out_st_q;

	// a failed item always carries a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != ST_OK) |-> (out_res_q == '0))
		else $error("nonzero result with error status");

	// the entry count never passes the store capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// an empty store has no last row and a nonempty one has
	assert property (@(posedge clk) disable iff (!arst_n)
		(last_q == '0) == (count_q == '0))
		else $error("last insert row out of step with entry count");

	// a result beat only follows a finished item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside the finish step");

endmodule

`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking bench for the compressed-sparse-row matrix store
// drives items and register writes, predicts each result and checks it in order
// depends on csr_sms_pkg and csr_sparse_matrix_store_top

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import csr_sms_pkg::*;

	localparam int unsigned ROWS_MAX = 256;
	localparam int unsigned COLS_MAX = 256;
	localparam int unsigned STORE_DEPTH = 1024;
	localparam int unsigned RANDOM_ITEMS = 120;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES = 40;
	// worst item is a full-store trace plus stalls; the limit allows it several times over
	localparam int unsigned CYCLE_LIMIT = 25_000_000;
	// register indexes that hold no register
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [RES_W-1:0] value;
		status_t          code;
	} csr_result_t;

	// shadow of the store plus the queue of results still owed by the block
	class csr_result_board;
		logic [VAL_W-1:0] entry_vals [STORE_DEPTH];
		logic [IDX_W-1:0] entry_cols [STORE_DEPTH];
		int unsigned      row_ptr [ROWS_MAX+1];
		int unsigned      stored;
		int unsigned      last_row;
		logic [IDX_W-1:0] rows_reg = 9'd256;
		logic [IDX_W-1:0] cols_reg = 9'd256;
		csr_result_t      pending_results [$];
		int unsigned      mismatches;
		int unsigned      checked;
		int unsigned      status_seen [5];

		function void write_register(logic [1:0] idx, logic [IDX_W-1:0] data);
			if (idx == CFG_NUM_ROWS)
				rows_reg = data;
			else if (idx == CFG_NUM_COLS)
				cols_reg = data;
		endfunction

		// registers above the maximum count as the maximum
		function int unsigned rows_used();
			return (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
		endfunction

		function int unsigned cols_used();
			return (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
		endfunction

		// first entry of row r whose column is c, sign-extended, else zero
		function logic [RES_W-1:0] find_in_row(int unsigned r, int unsigned c);
			for (int unsigned k = row_ptr[r-1]; k < row_ptr[r] && k < STORE_DEPTH; k++)
				if (entry_cols[k] == c)
					return {{(RES_W-VAL_W){entry_vals[k][VAL_W-1]}}, entry_vals[k]};
			return '0;
		endfunction

		// accepted item beat: update the shadow and queue the result it owes
		function void note_item(kind_t k, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
				logic [VAL_W-1:0] v);
			int unsigned n;
			int unsigned m;
			bit          in_range;
			csr_result_t res;
			n = rows_used();
			m = cols_used();
			in_range = (r >= 1) && (r <= n) && (c >= 1) && (c <= m);
			res.value = '0;
			res.code = ST_OK;
			case (k)
				K_INSERT: begin
					// bounds first, then zero skip, then row order, then fullness
					if (!in_range)
						res.code = ST_RANGE;
					else if (v == '0)
						res.code = ST_OK;
					else if (r < last_row)
						res.code = ST_ORDER;
					else if (stored >= STORE_DEPTH)
						res.code = ST_FULL;
					else begin
						entry_vals[stored] = v;
						entry_cols[stored] = c;
						stored++;
						last_row = r;
						for (int unsigned q = r; q <= ROWS_MAX; q++)
							row_ptr[q]++;
					end
				end
				K_READ: begin
					if (!in_range)
						res.code = ST_RANGE;
					else
						res.value = find_in_row(r, c);
				end
				K_TRACE: begin
					// sum wraps at the result width
					if (n != m)
						res.code = ST_NOT_SQUARE;
					else
						for (int unsigned d = 1; d <= n; d++)
							res.value += find_in_row(d, d);
				end
				default: begin
					for (int unsigned q = 0; q <= ROWS_MAX; q++)
						row_ptr[q] = 0;
					stored = 0;
					last_row = 0;
				end
			endcase
			pending_results.insert(pending_results.size(), res);
		endfunction

		// accepted result beat: compare with the oldest owed result
		function void check_result(logic [RES_W-1:0] v, logic [2:0] s);
			csr_result_t want;
			checked++;
			if (s <= ST_ORDER)
				status_seen[s]++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none pending, value %h status %0d", $time, v, s);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (v !== want.value) begin
				$display("%0t: result_value mismatch, expected %h actual %h",
					$time, want.value, v);
				mismatches++;
			end
			if (s !== want.code) begin
				$display("%0t: status mismatch, expected %0d actual %0d", $time, want.code, s);
				mismatches++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              kind = K_INSERT;
	logic [IDX_W-1:0]        row_index = '0;
	logic [IDX_W-1:0]        col_index = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [RES_W-1:0] result_value;
	logic [2:0]              status;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [1:0]              cfg_index = CFG_NUM_ROWS;
	logic [IDX_W-1:0]        cfg_data = '0;

	csr_result_board board = new;

	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned limit_settings = 0;
	bit          sender_gaps = 1'b1;
	bit          ready_stalls = 1'b1;
	int unsigned stall_left = 0;
	int unsigned stall_roll;

	csr_sparse_matrix_store_top #(
		.MAX_ROWS(ROWS_MAX),
		.MAX_COLS(COLS_MAX),
		.CAPACITY(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.row_index(row_index),
		.col_index(col_index),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycles, board.pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// record every accepted beat
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			board.write_register(cfg_index, cfg_data);
		if (in_valid && in_ready)
			board.note_item(kind_t'(kind), row_index, col_index, value);
		if (out_valid && out_ready)
			board.check_result(result_value, status);
	end

	// result side back-pressure: mostly short stalls, a few long ones
	always @(posedge clk) begin
		if (!ready_stalls)
			out_ready <= 1'b1;
		else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 25)
				stall_left = $urandom_range(1, 3);
			else if (stall_roll < 28)
				stall_left = $urandom_range(10, 60);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (!sender_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// nonzero most of the time, extremes now and then
	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return '0;
		if (roll < 9)
			return 32'h7fff_ffff;
		if (roll < 12)
			return 32'h8000_0000;
		if (roll < 15)
			return 32'hffff_ffff;
		if (roll < 17)
			return 32'h0001_0000;
		return $urandom;
	endfunction

	// one item beat; valid stays high on return so back-to-back beats need no toggle
	task automatic send_item(kind_t k, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
			logic [VAL_W-1:0] v);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		row_index <= r;
		col_index <= c;
		value <= v;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// hold items back until the block owes nothing
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_register(logic [1:0] idx, logic [IDX_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic put_limits(logic [IDX_W-1:0] rows, logic [IDX_W-1:0] cols);
		put_register(CFG_NUM_ROWS, rows);
		put_register(CFG_NUM_COLS, cols);
		cfg_valid <= 1'b0;
		limit_settings++;
	endtask

	// extremes of every field and each special case, at the reset limits first
	task automatic run_directed();
		send_item(K_READ, 1, 1, 0);
		send_item(K_TRACE, 0, 0, 0);
		send_item(K_INSERT, 1, 1, 32'h7fff_ffff);
		send_item(K_INSERT, 1, 256, 32'h8000_0000);
		// zero insert is skipped
		send_item(K_INSERT, 1, 2, 0);
		// out of range on each side
		send_item(K_INSERT, 0, 1, 5);
		send_item(K_INSERT, 1, 0, 5);
		send_item(K_INSERT, 257, 1, 5);
		send_item(K_INSERT, 9'h1ff, 9'h1ff, 32'hffff_ffff);
		send_item(K_INSERT, 256, 256, 32'hffff_ffff);
		// lower row than the last stored one
		send_item(K_INSERT, 2, 2, 1);
		send_item(K_READ, 1, 1, 0);
		send_item(K_READ, 1, 256, 0);
		send_item(K_READ, 256, 256, 0);
		send_item(K_READ, 1, 3, 0);
		send_item(K_READ, 9'h1ff, 1, 0);
		send_item(K_TRACE, 0, 0, 0);
		send_item(K_CLEAR, 0, 0, 0);
		send_item(K_READ, 1, 1, 0);
		// non-square limits
		drain_results();
		put_limits(3, 5);
		send_item(K_TRACE, 0, 0, 0);
		send_item(K_READ, 4, 1, 0);
		// zero limits: nothing in range, empty trace is fine
		drain_results();
		put_limits(0, 0);
		send_item(K_TRACE, 0, 0, 0);
		send_item(K_INSERT, 1, 1, 7);
	endtask

	// phases of row-major insert runs with reads and traces, plus noise
	task automatic run_random_phases();
		int unsigned      stop_at;
		int unsigned      phase_no;
		int unsigned      n;
		int unsigned      m;
		int unsigned      cursor;
		int unsigned      roll;
		int unsigned      c;
		logic [IDX_W-1:0] rows_cfg;
		logic [IDX_W-1:0] cols_cfg;
		logic [IDX_W-1:0] r_bad;
		logic [IDX_W-1:0] c_bad;
		logic [2*IDX_W-1:0] spot;
		logic [2*IDX_W-1:0] placed_cells [$];
		stop_at = items_sent + RANDOM_ITEMS;
		phase_no = 0;
		cursor = 1;
		while (items_sent < stop_at) begin
			drain_results();
			case (phase_no % 8)
				0: begin
					rows_cfg = 1;
					cols_cfg = 1;
				end
				1: begin
					rows_cfg = 0;
					cols_cfg = 0;
				end
				2: begin
					rows_cfg = 9'h1ff;
					cols_cfg = 9'h1ff;
					// writes to indexes with no register behind them
					put_register(CFG_SPARE_LO, 9'h1ff);
					put_register(CFG_SPARE_HI, 9'h000);
				end
				3: begin
					rows_cfg = 256;
					cols_cfg = 256;
				end
				4: begin
					rows_cfg = 0;
					cols_cfg = IDX_W'($urandom_range(1, 8));
				end
				5: begin
					rows_cfg = IDX_W'($urandom_range(2, 16));
					cols_cfg = rows_cfg;
				end
				6: begin
					rows_cfg = IDX_W'($urandom_range(1, 12));
					cols_cfg = IDX_W'($urandom_range(1, 12));
				end
				default: begin
					rows_cfg = IDX_W'($urandom_range(0, 511));
					cols_cfg = IDX_W'($urandom_range(0, 511));
				end
			endcase
			put_limits(rows_cfg, cols_cfg);
			n = (rows_cfg > ROWS_MAX) ? ROWS_MAX : rows_cfg;
			m = (cols_cfg > COLS_MAX) ? COLS_MAX : cols_cfg;
			sender_gaps = ($urandom_range(0, 3) != 0);
			ready_stalls = ($urandom_range(0, 3) != 0);
			if (phase_no == 0 || $urandom_range(0, 4) != 0) begin
				send_item(K_CLEAR, IDX_W'($urandom), IDX_W'($urandom), $urandom);
				cursor = 1;
				placed_cells.delete();
			end
			if (cursor > n)
				cursor = (n == 0) ? 1 : n;

			repeat ($urandom_range(6, 16)) begin
				roll = $urandom_range(0, 99);
				if (roll < 50) begin
					// well-formed insert, walking down the rows
					if (n == 0 || m == 0)
						send_item(K_INSERT, IDX_W'($urandom), IDX_W'($urandom), pick_value());
					else begin
						if ($urandom_range(0, 2) == 0)
							cursor += $urandom_range(1, 3);
						if (cursor > n)
							cursor = n;
						c = $urandom_range(1, m);
						send_item(K_INSERT, IDX_W'(cursor), IDX_W'(c), pick_value());
						spot = {IDX_W'(cursor), IDX_W'(c)};
						placed_cells.insert(placed_cells.size(), spot);
					end
				end else if (roll < 70) begin
					// read, mostly at a spot that was written
					if (placed_cells.size() != 0 && $urandom_range(0, 3) != 0) begin
						spot = placed_cells[$urandom_range(0, placed_cells.size() - 1)];
						send_item(K_READ, spot[2*IDX_W-1:IDX_W], spot[IDX_W-1:0], $urandom);
					end else if (n != 0 && m != 0)
						send_item(K_READ, IDX_W'($urandom_range(1, n)),
							IDX_W'($urandom_range(1, m)), $urandom);
					else
						send_item(K_READ, IDX_W'($urandom), IDX_W'($urandom), $urandom);
				end else if (roll < 78)
					send_item(K_TRACE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
				else if (roll < 85) begin
					// broken insert: out of bounds or out of row order
					r_bad = (n == 0) ? IDX_W'(1) : IDX_W'($urandom_range(1, n));
					c_bad = (m == 0) ? IDX_W'(1) : IDX_W'($urandom_range(1, m));
					case ($urandom_range(0, 4))
						0: r_bad = 0;
						1: c_bad = 0;
						2: r_bad = IDX_W'($urandom_range(n + 1, 511));
						3: c_bad = IDX_W'($urandom_range(m + 1, 511));
						default: r_bad = (cursor > 1) ? IDX_W'($urandom_range(1, cursor - 1))
							: IDX_W'(0);
					endcase
					send_item(K_INSERT, r_bad, c_bad, pick_value());
				end else if (roll < 90)
					send_item(kind_t'($urandom_range(0, 3)), IDX_W'($urandom), IDX_W'($urandom),
						$urandom);
				else if (roll < 92) begin
					send_item(K_CLEAR, IDX_W'($urandom), IDX_W'($urandom), $urandom);
					cursor = 1;
					placed_cells.delete();
				end else if (roll < 94)
					drain_results();
				else
					send_item(K_READ, IDX_W'($urandom), IDX_W'($urandom), $urandom);
			end
			phase_no++;
		end
	endtask

	// fill every slot in row order, then push past the end
	task automatic run_capacity_fill();
		logic [VAL_W-1:0] v;
		int unsigned      c;
		drain_results();
		put_limits(256, 256);
		sender_gaps = 1'b1;
		ready_stalls = 1'b1;
		send_item(K_CLEAR, 0, 0, 0);
		for (int unsigned r = 1; r <= ROWS_MAX; r++) begin
			for (int unsigned e = 0; e < STORE_DEPTH / ROWS_MAX; e++) begin
				c = (e == 0 && $urandom_range(0, 1) == 1) ? r : $urandom_range(1, COLS_MAX);
				do v = $urandom; while (v == '0);
				send_item(K_INSERT, IDX_W'(r), IDX_W'(c), v);
			end
			if (r % 64 == 0)
				send_item(K_READ, IDX_W'(r), IDX_W'(r), $urandom);
		end
		send_item(K_TRACE, 0, 0, 0);
		// store full, then row order wins over full, then bounds, then zero skip
		send_item(K_INSERT, 256, 1, 1);
		send_item(K_INSERT, 100, 1, 5);
		send_item(K_INSERT, 0, 1, 5);
		send_item(K_INSERT, 256, 7, 0);
		send_item(K_READ, 256, 256, 0);
		send_item(K_READ, 1, 300, 0);
		send_item(K_CLEAR, 0, 0, 0);
		send_item(K_TRACE, 0, 0, 0);
		send_item(K_INSERT, 1, 1, 5);
		send_item(K_READ, 1, 1, 0);
	endtask

	// reset, stimulus, final check
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random_phases();
		run_capacity_fill();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d items over %0d limit settings, %0d results checked",
			items_sent, limit_settings, board.checked);
		$display("statuses: ok %0d, range %0d, not square %0d, full %0d, row order %0d",
			board.status_seen[ST_OK], board.status_seen[ST_RANGE],
			board.status_seen[ST_NOT_SQUARE], board.status_seen[ST_FULL],
			board.status_seen[ST_ORDER]);
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
